FILE: design/wtq_pkg.sv
// Shared widths, action and status codes, and the compare unit's result
// type for the wake-time ordered event queue. No dependencies.
`default_nettype none

package wtq_pkg;

  localparam int ID_W   = 16;
  localparam int DATA_W = 16;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 48;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SCHED   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NODUE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_PAST     = 3'd4;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd5;

  typedef struct packed {
    logic id_eq;    // entry id equals key id
    logic wake_gt;  // entry wake time later than key time
  } wtq_cmp_t;

endpackage

`default_nettype wire

FILE: design/wtq_cmp.sv
// Shared compare unit: id match and wake-time order of one table entry
// against the key. Depends on wtq_pkg.
`default_nettype none

module wtq_cmp #(
  parameter int TIME_BITS = wtq_pkg::DEF_TIME_BITS
) (
  input  logic [wtq_pkg::ID_W-1:0] ent_id,
  input  logic [TIME_BITS-1:0]     ent_wake,
  input  logic [wtq_pkg::ID_W-1:0] key_id,
  input  logic [TIME_BITS-1:0]     key_wake,
  output wtq_pkg::wtq_cmp_t        cmp
);
  import wtq_pkg::*;

  always_comb begin
    cmp.id_eq   = (ent_id == key_id);
    cmp.wake_gt = (ent_wake > key_wake);
  end

endmodule

`default_nettype wire

FILE: design/wake_time_ordered_event_queue.sv
// Wake-time ordered event queue: sorted task table in a one-read, one-write RAM
// walked by a sequencer around one shared compare unit. Depends on wtq_pkg, wtq_cmp.
// Tick and unused codes go straight to the result; pop checks the head, then shifts;
// replace scans, then writes; remove scans, then shifts; schedule scans, shifts,
// then writes; a rejected scan-based word ends after the scan. The id scan and the
// shift each move one entry per cycle through the table RAM (one read, one write
// per cycle). One word is in work at a time: in_ready returns with out_valid,
// and a result waits while the output register holds an untaken result.
// Reset: time and task count clear; table contents are never read above count.
`default_nettype none

module wake_time_ordered_event_queue #(
  parameter int QUEUE_DEPTH = wtq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = wtq_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wtq_pkg::ACT_W-1:0]          in_action,
  input  logic [wtq_pkg::ID_W-1:0]           in_entry_id,
  input  logic [wtq_pkg::DATA_W-1:0]         in_entry_data,
  input  logic [TIME_BITS-1:0]               in_wake_time,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic [wtq_pkg::STAT_W-1:0]         out_status,
  output logic [wtq_pkg::ID_W-1:0]           out_id,
  output logic [wtq_pkg::DATA_W-1:0]         out_data,
  output logic [TIME_BITS-1:0]               out_wake_time,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_pending
);
  import wtq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = ID_W + DATA_W + TIME_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // id / insert-point walk
  localparam logic [2:0] S_HEAD  = 3'd2;  // pop: head due check
  localparam logic [2:0] S_SHIFT = 3'd3;  // move entries one slot
  localparam logic [2:0] S_WRITE = 3'd4;  // final table write
  localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output reg

  logic [2:0]            state_r, state_nxt;

  // latched request
  logic [ACT_W-1:0]      op_r, op_nxt;
  logic [ID_W-1:0]       key_id_r, key_id_nxt;
  logic [DATA_W-1:0]     key_data_r, key_data_nxt;
  logic [TIME_BITS-1:0]  key_wake_r, key_wake_nxt;

  // architectural state
  logic [TIME_BITS-1:0]  cur_time_r, cur_time_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  // scan pipeline: issue index and the compare slot, which sees each entry in the cycle after its issue
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic                  ins_found_r, ins_found_nxt;
  logic [CNT_W-1:0]      ins_r, ins_nxt;
  logic [ENT_W-1:0]      hit_r, hit_nxt;

  // shift engine: read one slot, write it to its neighbor next cycle
  logic [IDX_W-1:0]      sh_idx_r, sh_idx_nxt;
  logic [CNT_W-1:0]      sh_left_r, sh_left_nxt;
  logic                  sh_up_r, sh_up_nxt;      // 1: close a gap (delete)
  logic                  pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]      pend_addr_r, pend_addr_nxt;

  // staged result
  logic                  res_ok_r, res_ok_nxt;
  logic [STAT_W-1:0]     res_status_r, res_status_nxt;
  logic [ID_W-1:0]       res_id_r, res_id_nxt;
  logic [DATA_W-1:0]     res_data_r, res_data_nxt;
  logic [TIME_BITS-1:0]  res_wake_r, res_wake_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [TIME_BITS-1:0]  out_wake_r, out_wake_nxt;
  logic [CNT_W-1:0]      out_pending_r, out_pending_nxt;

  // task table RAM, word = {id, data, wake}
  logic [ENT_W-1:0]      mem_r [QUEUE_DEPTH];
  logic [ENT_W-1:0]      rd_data_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_word;

  // shared compare unit
  logic [ID_W-1:0]       ent_id;
  logic [DATA_W-1:0]     ent_data;
  logic [TIME_BITS-1:0]  ent_wake;
  logic [TIME_BITS-1:0]  cmp_key_wake;
  wtq_cmp_t              cmp;

  assign ent_id   = rd_data_r[ENT_W-1 -: ID_W];
  assign ent_data = rd_data_r[TIME_BITS +: DATA_W];
  assign ent_wake = rd_data_r[TIME_BITS-1:0];

  // pop checks the head against current time; scans against the new wake time
  assign cmp_key_wake = (op_r == ACT_POP) ? cur_time_r : key_wake_r;

  wtq_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .ent_id   (ent_id),
    .ent_wake (ent_wake),
    .key_id   (key_id_r),
    .key_wake (cmp_key_wake),
    .cmp      (cmp)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_id_nxt      = key_id_r;
    key_data_nxt    = key_data_r;
    key_wake_nxt    = key_wake_r;
    cur_time_nxt    = cur_time_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    pos_nxt         = pos_r;
    ins_found_nxt   = ins_found_r;
    ins_nxt         = ins_r;
    hit_nxt         = hit_r;
    sh_idx_nxt      = sh_idx_r;
    sh_left_nxt     = sh_left_r;
    sh_up_nxt       = sh_up_r;
    pend_vld_nxt    = pend_vld_r;
    pend_addr_nxt   = pend_addr_r;
    res_ok_nxt      = res_ok_r;
    res_status_nxt  = res_status_r;
    res_id_nxt      = res_id_r;
    res_data_nxt    = res_data_r;
    res_wake_nxt    = res_wake_r;
    out_valid_nxt   = out_valid_r;
    out_ok_nxt      = out_ok_r;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_data_nxt    = out_data_r;
    out_wake_nxt    = out_wake_r;
    out_pending_nxt = out_pending_r;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_word         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_action;
          key_id_nxt     = in_entry_id;
          key_data_nxt   = in_entry_data;
          key_wake_nxt   = in_wake_time;
          idx_nxt        = '0;
          cmp_vld_nxt    = 1'b0;
          found_nxt      = 1'b0;
          ins_found_nxt  = 1'b0;
          ins_nxt        = count_r;   // append unless a later wake is seen
          res_ok_nxt     = 1'b1;
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_data_nxt   = '0;
          res_wake_nxt   = '0;
          unique case (in_action) inside
            ACT_SCHED, ACT_REMOVE, ACT_REPLACE: begin
              state_nxt = S_SCAN;
            end
            ACT_POP: begin
              if (count_r == '0) begin
                res_ok_nxt     = 1'b0;
                res_status_nxt = ST_NODUE;
                state_nxt      = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_HEAD;
              end
            end
            ACT_TICK: begin
              cur_time_nxt = cur_time_r + TIME_BITS'(1);
              state_nxt    = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue side
        if (idx_r < count_r) begin
          rd_en       = 1'b1;
          rd_addr     = idx_r[IDX_W-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        // compare side, one entry behind
        if (cmp_vld_r) begin
          if (cmp.id_eq && !found_r) begin
            found_nxt = 1'b1;
            pos_nxt   = cmp_idx_r;
            hit_nxt   = rd_data_r;
          end
          if (cmp.wake_gt && !ins_found_r) begin
            ins_found_nxt = 1'b1;
            ins_nxt       = CNT_W'(cmp_idx_r);
          end
        end
        // walk finished: nothing left to issue and nothing in flight
        if (!cmp_vld_r && !(idx_r < count_r)) begin
          unique case (op_r)
            ACT_SCHED: begin
              if (found_r) begin
                res_ok_nxt     = 1'b0;
                res_status_nxt = ST_DUP;
                state_nxt      = S_DONE;
              end else if (key_wake_r < cur_time_r) begin
                res_ok_nxt     = 1'b0;
                res_status_nxt = ST_PAST;
                state_nxt      = S_DONE;
              end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_ok_nxt     = 1'b0;
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                // open a hole at the insert point, top entry first
                sh_idx_nxt   = IDX_W'(count_r - CNT_W'(1));
                sh_left_nxt  = count_r - ins_r;
                sh_up_nxt    = 1'b0;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_SHIFT;
              end
            end
            ACT_REMOVE: begin
              if (!found_r) begin
                res_ok_nxt     = 1'b0;
                res_status_nxt = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end else begin
                res_id_nxt   = hit_r[ENT_W-1 -: ID_W];
                res_data_nxt = hit_r[TIME_BITS +: DATA_W];
                res_wake_nxt = hit_r[TIME_BITS-1:0];
                sh_idx_nxt   = pos_r + IDX_W'(1);
                sh_left_nxt  = count_r - CNT_W'(1) - CNT_W'(pos_r);
                sh_up_nxt    = 1'b1;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_SHIFT;
              end
            end
            ACT_REPLACE: begin
              if (!found_r) begin
                res_ok_nxt     = 1'b0;
                res_status_nxt = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end else begin
                res_id_nxt   = hit_r[ENT_W-1 -: ID_W];
                res_data_nxt = hit_r[TIME_BITS +: DATA_W];
                res_wake_nxt = hit_r[TIME_BITS-1:0];
                state_nxt    = S_WRITE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_HEAD: begin
        if (cmp.wake_gt) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = ST_NODUE;
          state_nxt      = S_DONE;
        end else begin
          res_id_nxt   = ent_id;
          res_data_nxt = ent_data;
          res_wake_nxt = ent_wake;
          sh_idx_nxt   = IDX_W'(1);
          sh_left_nxt  = count_r - CNT_W'(1);
          sh_up_nxt    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (sh_left_r != '0) begin
          rd_en        = 1'b1;
          rd_addr      = sh_idx_r;
          pend_vld_nxt = 1'b1;
          if (sh_up_r) begin
            pend_addr_nxt = sh_idx_r - IDX_W'(1);
            sh_idx_nxt    = sh_idx_r + IDX_W'(1);
          end else begin
            pend_addr_nxt = sh_idx_r + IDX_W'(1);
            sh_idx_nxt    = sh_idx_r - IDX_W'(1);
          end
          sh_left_nxt = sh_left_r - CNT_W'(1);
        end else begin
          pend_vld_nxt = 1'b0;
        end
        if (pend_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_word = rd_data_r;
        end
        if (sh_left_r == '0 && !pend_vld_r) begin
          if (op_r == ACT_SCHED) begin
            state_nxt = S_WRITE;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end

      S_WRITE: begin
        wr_en = 1'b1;
        if (op_r == ACT_SCHED) begin
          wr_addr      = ins_r[IDX_W-1:0];
          wr_word      = {key_id_r, key_data_r, key_wake_r};
          count_nxt    = count_r + CNT_W'(1);
          res_id_nxt   = key_id_r;
          res_data_nxt = key_data_r;
          res_wake_nxt = key_wake_r;
        end else begin
          wr_addr = pos_r;
          wr_word = {hit_r[ENT_W-1 -: ID_W], key_data_r, hit_r[TIME_BITS-1:0]};
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_ok_nxt      = res_ok_r;
          out_status_nxt  = res_status_r;
          out_id_nxt      = res_id_r;
          out_data_nxt    = res_data_r;
          out_wake_nxt    = res_wake_r;
          out_pending_nxt = count_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_time_r  <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_time_r  <= cur_time_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_id_r      <= key_id_nxt;
    key_data_r    <= key_data_nxt;
    key_wake_r    <= key_wake_nxt;
    idx_r         <= idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    found_r       <= found_nxt;
    pos_r         <= pos_nxt;
    ins_found_r   <= ins_found_nxt;
    ins_r         <= ins_nxt;
    hit_r         <= hit_nxt;
    sh_idx_r      <= sh_idx_nxt;
    sh_left_r     <= sh_left_nxt;
    sh_up_r       <= sh_up_nxt;
    pend_addr_r   <= pend_addr_nxt;
    res_ok_r      <= res_ok_nxt;
    res_status_r  <= res_status_nxt;
    res_id_r      <= res_id_nxt;
    res_data_r    <= res_data_nxt;
    res_wake_r    <= res_wake_nxt;
    out_ok_r      <= out_ok_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_data_r    <= out_data_nxt;
    out_wake_r    <= out_wake_nxt;
    out_pending_r <= out_pending_nxt;
  end

  // table RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_r;
  assign out_data      = out_data_r;
  assign out_wake_time = out_wake_r;
  assign out_pending   = out_pending_r;

  // task count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("task count above table depth");

  // count moves by at most one per operation step
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) ||
    (count_r == $past(count_r) - CNT_W'(1)))
    else $error("task count jumped");

  // ok flag and status agree
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_status == ST_OK)))
    else $error("ok flag disagrees with status");

  // failed operations report an empty task
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_id == '0 && out_data == '0 && out_wake_time == '0))
    else $error("failed result carries task fields");

endmodule

`default_nettype wire
